// File: rtl/core/bdlp_pkg.sv
// Shared types, constants and event codes for the button debounce / long-press unit.
`timescale 1ns / 1ps
package bdlp_pkg;

  // Default sizing
  localparam int MAX_BUTTONS_DEF = 32;
  localparam int TIME_BITS_DEF   = 16;

  // Field widths
  localparam int BTN_W  = 5;
  localparam int CODE_W = 2;
  localparam int SCAN_W = 10;
  localparam int MS_W   = 16;
  localparam int EN_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EVENT_EN    = 2'd3;

  // Register reset values
  localparam logic [SCAN_W-1:0] SCAN_PERIOD_RST = 10'd10;
  localparam logic [MS_W-1:0]   DEBOUNCE_RST    = 16'd50;
  localparam logic [MS_W-1:0]   LONG_PRESS_RST  = 16'd1000;
  localparam logic [EN_W-1:0]   EVENT_EN_RST    = 4'hF;

  // Event codes
  localparam logic [CODE_W-1:0] EV_PRESS      = 2'd0;
  localparam logic [CODE_W-1:0] EV_LONG_START = 2'd1;
  localparam logic [CODE_W-1:0] EV_LONG_REL   = 2'd2;
  localparam logic [CODE_W-1:0] EV_CLICK_REL  = 2'd3;

  typedef struct packed {
    logic [BTN_W-1:0] button_index;
    logic             pressed;
  } in_word_t;

  typedef struct packed {
    logic [BTN_W-1:0]  event_button;
    logic [CODE_W-1:0] event_code;
  } out_word_t;

  typedef struct packed {
    logic [SCAN_W-1:0] scan_period_ms;
    logic [MS_W-1:0]   debounce_ms;
    logic [MS_W-1:0]   long_press_ms;
    logic [EN_W-1:0]   event_enable;
  } cfg_t;

  // Per-button status flags
  typedef struct packed {
    logic is_pressed;
    logic in_debounce;
    logic long_reported;
  } btn_flags_t;

endpackage

// File: rtl/core/bdlp_cfg.sv
// Configuration register bank.
`timescale 1ns / 1ps
module bdlp_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bdlp_pkg::CFG_DATA_W-1:0]     cfg_data,
  output bdlp_pkg::cfg_t                      cfg
);

  // Register writes, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_period_ms <= bdlp_pkg::SCAN_PERIOD_RST;
      cfg.debounce_ms    <= bdlp_pkg::DEBOUNCE_RST;
      cfg.long_press_ms  <= bdlp_pkg::LONG_PRESS_RST;
      cfg.event_enable   <= bdlp_pkg::EVENT_EN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bdlp_pkg::REG_SCAN_PERIOD: cfg.scan_period_ms <= cfg_data[bdlp_pkg::SCAN_W-1:0];
        bdlp_pkg::REG_DEBOUNCE:    cfg.debounce_ms    <= cfg_data[bdlp_pkg::MS_W-1:0];
        bdlp_pkg::REG_LONG_PRESS:  cfg.long_press_ms  <= cfg_data[bdlp_pkg::MS_W-1:0];
        bdlp_pkg::REG_EVENT_EN:    cfg.event_enable   <= cfg_data[bdlp_pkg::EN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/bdlp_state.sv
// Per-button state file: flags, debounce countdown and hold time.
`timescale 1ns / 1ps
module bdlp_state #(
  parameter int MAX_BUTTONS = bdlp_pkg::MAX_BUTTONS_DEF,
  parameter int TIME_BITS   = bdlp_pkg::TIME_BITS_DEF,
  parameter int IDX_W       = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [IDX_W-1:0]     idx,
  input  logic                 we,
  input  bdlp_pkg::btn_flags_t flags_wr,
  input  logic [TIME_BITS-1:0] left_wr,
  input  logic [TIME_BITS-1:0] hold_wr,
  output bdlp_pkg::btn_flags_t flags_rd,
  output logic [TIME_BITS-1:0] left_rd,
  output logic [TIME_BITS-1:0] hold_rd
);

  bdlp_pkg::btn_flags_t flags [MAX_BUTTONS];
  logic [TIME_BITS-1:0] debounce_left [MAX_BUTTONS];
  logic [TIME_BITS-1:0] hold_time [MAX_BUTTONS];

  // Flags and hold time clear on reset; countdown is loaded before use
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_BUTTONS; i++) begin
        flags[i]     <= '0;
        hold_time[i] <= '0;
      end
    end else if (we) begin
      flags[idx]     <= flags_wr;
      hold_time[idx] <= hold_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      debounce_left[idx] <= left_wr;
    end
  end

  // Read port at the current item's button
  assign flags_rd = flags[idx];
  assign left_rd  = debounce_left[idx];
  assign hold_rd  = hold_time[idx];

endmodule

// File: rtl/core/bdlp_eval.sv
// Next-state and event logic for one sample of one button.
`timescale 1ns / 1ps
module bdlp_eval #(
  parameter int TIME_BITS = bdlp_pkg::TIME_BITS_DEF
) (
  input  bdlp_pkg::cfg_t                  cfg,
  input  logic                            pressed,
  input  bdlp_pkg::btn_flags_t            flags,
  input  logic [TIME_BITS-1:0]            left,
  input  logic [TIME_BITS-1:0]            hold,
  output bdlp_pkg::btn_flags_t            flags_next,
  output logic [TIME_BITS-1:0]            left_next,
  output logic [TIME_BITS-1:0]            hold_next,
  output logic                            fire,
  output logic [bdlp_pkg::CODE_W-1:0]     code
);

  localparam int SW = ((TIME_BITS > bdlp_pkg::SCAN_W) ? TIME_BITS : bdlp_pkg::SCAN_W) + 1;
  localparam int RW = SW + 1;
  localparam int CW = (TIME_BITS > bdlp_pkg::MS_W) ? TIME_BITS : bdlp_pkg::MS_W;

  logic [TIME_BITS-1:0] time_max;
  logic [CW-1:0]        deb_ext;
  logic [TIME_BITS-1:0] deb_sat;
  logic signed [RW-1:0] rest;
  logic                 rest_pos;
  logic [SW-1:0]        hold_sum;
  logic [TIME_BITS-1:0] hold_sat;
  logic                 long_hit;
  logic                 ev;

  assign time_max = '1;

  // Debounce load value, saturated to the time range
  assign deb_ext = CW'(cfg.debounce_ms);
  assign deb_sat = (deb_ext > CW'(time_max)) ? time_max : deb_ext[TIME_BITS-1:0];

  // Signed countdown step
  assign rest     = $signed(RW'(left)) - $signed(RW'(cfg.scan_period_ms));
  assign rest_pos = !rest[RW-1] && (rest != '0);

  // Saturating hold-time step and long-press compare
  assign hold_sum = SW'(hold) + SW'(cfg.scan_period_ms);
  assign hold_sat = (hold_sum > SW'(time_max)) ? time_max : hold_sum[TIME_BITS-1:0];
  assign long_hit = !(CW'(hold_sat) < CW'(cfg.long_press_ms));

  // Per-button state machine
  always_comb begin
    flags_next = flags;
    left_next  = left;
    hold_next  = hold;
    ev         = 1'b0;
    code       = bdlp_pkg::EV_PRESS;
    if (pressed) begin
      if (!flags.is_pressed) begin
        flags_next.is_pressed  = 1'b1;
        flags_next.in_debounce = 1'b1;
        left_next              = deb_sat;
      end else if (flags.in_debounce) begin
        if (rest_pos) begin
          left_next = rest[TIME_BITS-1:0];
        end else begin
          flags_next.in_debounce = 1'b0;
          ev                     = 1'b1;
          code                   = bdlp_pkg::EV_PRESS;
        end
      end else if ((cfg.long_press_ms != '0) && !flags.long_reported) begin
        hold_next = hold_sat;
        if (long_hit) begin
          flags_next.long_reported = 1'b1;
          ev                       = 1'b1;
          code                     = bdlp_pkg::EV_LONG_START;
        end
      end
    end else if (flags.is_pressed) begin
      flags_next.is_pressed = 1'b0;
      if (flags.in_debounce) begin
        // release before confirmation is dropped
        flags_next.in_debounce = 1'b0;
      end else begin
        left_next = '0;
        hold_next = '0;
        ev        = 1'b1;
        if (flags.long_reported) begin
          flags_next.long_reported = 1'b0;
          code                     = bdlp_pkg::EV_LONG_REL;
        end else begin
          code = bdlp_pkg::EV_CLICK_REL;
        end
      end
    end
  end

  // Event mask
  assign fire = ev && cfg.event_enable[code];

endmodule

// File: rtl/core/button_debounce_long_press_unit.sv
// The input register holds a word until it advances into the output register as its event.
// One input word per cycle unless stalled; per-button state is read and written on advance.
// The output register parts the sides: a stalled output holds the input register only.
// Reset (rst, synchronous): clears all button flags and hold times, loads register
// defaults, and empties the input and output registers.
`timescale 1ns / 1ps
module button_debounce_long_press_unit #(
  parameter int MAX_BUTTONS = bdlp_pkg::MAX_BUTTONS_DEF,
  parameter int TIME_BITS   = bdlp_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bdlp_pkg::in_word_t              in_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bdlp_pkg::out_word_t             out_word,
  input  logic                            cfg_we,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdlp_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
  localparam int EXT_W = 9;

  bdlp_pkg::cfg_t       cfg;
  bdlp_pkg::in_word_t   in_q;
  logic                 in_full;
  logic                 advance;
  logic [EXT_W-1:0]     idx_ext;
  logic                 in_range;
  logic [IDX_W-1:0]     idx;
  bdlp_pkg::btn_flags_t flags_rd;
  bdlp_pkg::btn_flags_t flags_next;
  logic [TIME_BITS-1:0] left_rd;
  logic [TIME_BITS-1:0] left_next;
  logic [TIME_BITS-1:0] hold_rd;
  logic [TIME_BITS-1:0] hold_next;
  logic                 fire;
  logic [bdlp_pkg::CODE_W-1:0] code;

  bdlp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: the input stage moves when the output register is free or being taken
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_word;
    end
  end

  // Button index range check
  assign idx_ext  = EXT_W'(in_q.button_index);
  assign in_range = idx_ext < EXT_W'(MAX_BUTTONS);
  assign idx      = idx_ext[IDX_W-1:0];

  bdlp_state #(
    .MAX_BUTTONS (MAX_BUTTONS),
    .TIME_BITS   (TIME_BITS),
    .IDX_W       (IDX_W)
  ) u_state (
    .clk      (clk),
    .rst      (rst),
    .idx      (idx),
    .we       (advance && in_range),
    .flags_wr (flags_next),
    .left_wr  (left_next),
    .hold_wr  (hold_next),
    .flags_rd (flags_rd),
    .left_rd  (left_rd),
    .hold_rd  (hold_rd)
  );

  bdlp_eval #(
    .TIME_BITS (TIME_BITS)
  ) u_eval (
    .cfg        (cfg),
    .pressed    (in_q.pressed),
    .flags      (flags_rd),
    .left       (left_rd),
    .hold       (hold_rd),
    .flags_next (flags_next),
    .left_next  (left_next),
    .hold_next  (hold_next),
    .fire       (fire),
    .code       (code)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && in_range;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word.event_button <= in_q.button_index;
      out_word.event_code   <= code;
    end
  end

`ifndef SYNTHESIS
  // Stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(in_q))
    else $error("input word lost while stalled");

  // Out-of-range buttons never produce an event
  a_range: assert property (@(posedge clk) disable iff (rst)
    advance && !in_range |=> !out_valid)
    else $error("event for out-of-range button");

  // Full input stage behind a stalled output takes nothing new
  a_backpress: assert property (@(posedge clk) disable iff (rst)
    in_full && out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // An emitted word carries the button of the word that caused it
  a_button: assert property (@(posedge clk) disable iff (rst)
    advance && fire && in_range |=> out_valid && out_word.event_button == $past(in_q.button_index))
    else $error("event button mismatch");
`endif

endmodule
